### src/atab_pkg.sv
// Package for the access tag table: sizes, operation codes and field widths.
`default_nettype none
package atab_pkg;

   localparam int TABLE_SLOTS = 32;
   localparam int TAG_BITS    = 32;

   // Width of the tag_id field and of the stored tag (the field holds 32 bits).
   localparam int TAG_FIELD_BITS = 32;
   localparam int STORE_BITS     = (TAG_BITS < TAG_FIELD_BITS) ? TAG_BITS : TAG_FIELD_BITS;

   localparam int SLOT_BITS  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int COUNT_BITS = $clog2(TABLE_SLOTS + 1);

   localparam int SLOT_FIELD_BITS  = 5;
   localparam int COUNT_FIELD_BITS = 6;

   localparam logic [1:0] OP_LOOKUP       = 2'd0;
   localparam logic [1:0] OP_ADMIN_LOOKUP = 2'd1;
   localparam logic [1:0] OP_ADD          = 2'd2;
   localparam logic [1:0] OP_DELETE       = 2'd3;

endpackage
`default_nettype wire

### src/atab_if.sv
// Request and response channel interfaces of the access tag table.
`default_nettype none
interface atab_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [atab_pkg::TAG_FIELD_BITS-1:0] tag_id;
   logic        grant_admin;

   modport source (output valid, operation, tag_id, grant_admin, input ready);
   modport sink   (input valid, operation, tag_id, grant_admin, output ready);
endinterface

interface atab_rsp_if;
   logic        valid;
   logic        ready;
   logic        success;
   logic [atab_pkg::SLOT_FIELD_BITS-1:0]  slot_index;
   logic        entry_admin;
   logic [atab_pkg::COUNT_FIELD_BITS-1:0] user_count;
   logic        table_empty;

   modport source (output valid, success, slot_index, entry_admin, user_count, table_empty,
                   input ready);
   modport sink   (input valid, success, slot_index, entry_admin, user_count, table_empty,
                   output ready);
endinterface
`default_nettype wire

### src/atab_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module atab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### src/access_tag_table.sv
// Access tag table top level: slot scan sequencer, valid bits, entry count and response register.
//
// The table holds TABLE_SLOTS tags, each with an admin flag, in one RAM with
// a single read port; valid bits and the entry count are kept in flip-flops
// and reset clears them at once, so no clearing pass is needed. Each
// transaction on req_port starts one scan that reads every slot through the
// RAM read port and a single tag comparator, noting the first matching slot
// and the lowest free slot; a drain state lets the last compare finish, a
// decide state applies the operation and a done state loads the response.
// A new request is taken only in the idle state, after the previous one has
// loaded its response, since the one RAM read port is walked once per item.
// A finished response waits in its output register while the next request is scanned.
`default_nettype none
module access_tag_table (
   input  wire logic clock,
   input  wire logic reset,
   atab_req_if.sink  req_port,
   atab_rsp_if.source rsp_port
);
   localparam int N  = atab_pkg::TABLE_SLOTS;
   localparam int SB = atab_pkg::SLOT_BITS;
   localparam int CB = atab_pkg::COUNT_BITS;
   localparam int TB = atab_pkg::STORE_BITS;

   localparam logic [SB-1:0] LAST_SLOT = SB'(N - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [N-1:0]  valid_ff, valid_in;
   logic [CB-1:0] count_ff, count_in;
   logic [SB-1:0] idx_ff, idx_in;
   logic          cmp_pend_ff, cmp_pend_in;
   logic [SB-1:0] cmp_idx_ff, cmp_idx_in;
   logic          found_ff, found_in;
   logic [SB-1:0] hit_idx_ff, hit_idx_in;
   logic          hit_admin_ff, hit_admin_in;
   logic          free_found_ff, free_found_in;
   logic [SB-1:0] free_idx_ff, free_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [1:0]    op_ff, op_in;
   logic [TB-1:0] tag_ff, tag_in;
   logic          grant_ff, grant_in;
   logic          res_ok_ff, res_ok_in;
   logic [SB-1:0] res_slot_ff, res_slot_in;
   logic          res_admin_ff, res_admin_in;
   logic          out_ok_ff, out_ok_in;
   logic [SB-1:0] out_slot_ff, out_slot_in;
   logic          out_admin_ff, out_admin_in;
   logic [CB-1:0] out_count_ff, out_count_in;

   logic          ram_wr_en;
   logic [SB-1:0] ram_wr_addr;
   logic [TB:0]   ram_wr_data;
   logic [TB:0]   ram_rd_data;

   logic          slot_hit;
   logic          slot_free;
   logic [SB-1:0] upgrade_slot;
   logic [SB+atab_pkg::SLOT_FIELD_BITS-1:0]  slot_wide;
   logic [CB+atab_pkg::COUNT_FIELD_BITS-1:0] count_wide;

   // Admin flag sits above the tag in each RAM word.
   atab_ram #(.WIDTH(TB + 1), .DEPTH(N)) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign slot_hit  = cmp_pend_ff && valid_ff[cmp_idx_ff] && (ram_rd_data[TB-1:0] == tag_ff);
   assign slot_free = cmp_pend_ff && !valid_ff[cmp_idx_ff];

   // After an upgrade frees the hit slot, the lowest free slot is the lower of the two.
   assign upgrade_slot = (free_found_ff && (free_idx_ff < hit_idx_ff)) ? free_idx_ff : hit_idx_ff;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_pend_in   = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_admin_in  = hit_admin_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      op_in         = op_ff;
      tag_in        = tag_ff;
      grant_in      = grant_ff;
      res_ok_in     = res_ok_ff;
      res_slot_in   = res_slot_ff;
      res_admin_in  = res_admin_ff;
      out_ok_in     = out_ok_ff;
      out_slot_in   = out_slot_ff;
      out_admin_in  = out_admin_ff;
      out_count_in  = out_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {1'b1, tag_ff};

      if (slot_hit && !found_ff) begin
         found_in     = 1'b1;
         hit_idx_in   = cmp_idx_ff;
         hit_admin_in = ram_rd_data[TB];
      end
      if (slot_free && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = cmp_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               op_in         = req_port.operation;
               tag_in        = req_port.tag_id[TB-1:0];
               grant_in      = req_port.grant_admin;
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmp_pend_in = 1'b1;
            cmp_idx_in  = idx_ff;
            if (idx_ff == LAST_SLOT) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + SB'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            res_ok_in    = 1'b0;
            res_slot_in  = '0;
            res_admin_in = 1'b0;
            case (op_ff)
               atab_pkg::OP_LOOKUP: begin
                  if (found_ff) begin
                     res_ok_in    = 1'b1;
                     res_slot_in  = hit_idx_ff;
                     res_admin_in = hit_admin_ff;
                  end
               end
               atab_pkg::OP_ADMIN_LOOKUP: begin
                  if (found_ff && hit_admin_ff) begin
                     res_ok_in    = 1'b1;
                     res_slot_in  = hit_idx_ff;
                     res_admin_in = 1'b1;
                  end
               end
               atab_pkg::OP_ADD: begin
                  if (found_ff) begin
                     if (grant_ff && !hit_admin_ff) begin
                        valid_in[hit_idx_ff]   = 1'b0;
                        valid_in[upgrade_slot] = 1'b1;
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = upgrade_slot;
                        ram_wr_data  = {1'b1, tag_ff};
                        res_ok_in    = 1'b1;
                        res_slot_in  = upgrade_slot;
                        res_admin_in = 1'b1;
                     end
                  end else if (free_found_ff) begin
                     valid_in[free_idx_ff] = 1'b1;
                     count_in     = count_ff + CB'(1);
                     ram_wr_en    = 1'b1;
                     ram_wr_addr  = free_idx_ff;
                     ram_wr_data  = {grant_ff, tag_ff};
                     res_ok_in    = 1'b1;
                     res_slot_in  = free_idx_ff;
                     res_admin_in = grant_ff;
                  end
               end
               atab_pkg::OP_DELETE: begin
                  if (found_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     count_in     = count_ff - CB'(1);
                     res_ok_in    = 1'b1;
                     res_slot_in  = hit_idx_ff;
                     res_admin_in = hit_admin_ff;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               out_ok_in    = res_ok_ff;
               out_slot_in  = res_slot_ff;
               out_admin_in = res_admin_ff;
               out_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         count_ff      <= '0;
         cmp_pend_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         cmp_pend_ff   <= cmp_pend_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_admin_ff <= hit_admin_in;
      free_idx_ff  <= free_idx_in;
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      grant_ff     <= grant_in;
      res_ok_ff    <= res_ok_in;
      res_slot_ff  <= res_slot_in;
      res_admin_ff <= res_admin_in;
      out_ok_ff    <= out_ok_in;
      out_slot_ff  <= out_slot_in;
      out_admin_ff <= out_admin_in;
      out_count_ff <= out_count_in;
   end

   // Slot index and count are reported modulo their field widths.
   assign slot_wide  = {{atab_pkg::SLOT_FIELD_BITS{1'b0}}, out_slot_ff};
   assign count_wide = {{atab_pkg::COUNT_FIELD_BITS{1'b0}}, out_count_ff};

   assign req_port.ready       = (state_ff == S_IDLE);
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.success     = out_ok_ff;
   assign rsp_port.slot_index  = slot_wide[atab_pkg::SLOT_FIELD_BITS-1:0];
   assign rsp_port.entry_admin = out_admin_ff;
   assign rsp_port.user_count  = count_wide[atab_pkg::COUNT_FIELD_BITS-1:0];
   assign rsp_port.table_empty = (out_count_ff == '0);

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == 32'($countones(valid_ff)))
      else $error("entry count differs from number of valid slots");

   a_fail_reports_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_ok_ff) |-> (out_slot_ff == '0 && !out_admin_ff))
      else $error("failed transaction reports a slot or admin flag");

   a_lookup_keeps_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && (op_ff == atab_pkg::OP_LOOKUP ||
       op_ff == atab_pkg::OP_ADMIN_LOOKUP)) |=> (valid_ff == $past(valid_ff)))
      else $error("lookup changed the table");
`endif

endmodule
`default_nettype wire

### bench/tb_access_tag_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for the access tag table: random and directed table operations.
module tb_access_tag_table;

   // Tracks the table contents as the block should hold them, and the replies still owed.
   class tag_table_scoreboard;
      typedef struct packed {
         logic                                  success;
         logic [atab_pkg::SLOT_FIELD_BITS-1:0]  slot_index;
         logic                                  entry_admin;
         logic [atab_pkg::COUNT_FIELD_BITS-1:0] user_count;
         logic                                  table_empty;
      } reply_type;

      bit                              occupied[atab_pkg::TABLE_SLOTS];
      logic [atab_pkg::STORE_BITS-1:0] stored_tag[atab_pkg::TABLE_SLOTS];
      bit                              is_admin[atab_pkg::TABLE_SLOTS];
      reply_type                       awaited[$];
      int                              failures = 0;

      function int find_tag(logic [atab_pkg::STORE_BITS-1:0] tag);
         for (int i = 0; i < atab_pkg::TABLE_SLOTS; i++)
            if (occupied[i] && stored_tag[i] == tag) return i;
         return -1;
      endfunction

      function int lowest_free();
         for (int i = 0; i < atab_pkg::TABLE_SLOTS; i++)
            if (!occupied[i]) return i;
         return -1;
      endfunction

      function void note_request(logic [1:0] op,
                                 logic [atab_pkg::TAG_FIELD_BITS-1:0] tag_field,
                                 logic grant);
         logic [atab_pkg::STORE_BITS-1:0] tag;
         int                              hit;
         int                              slot;
         int                              count;
         bit                              ok;
         bit                              adm;
         reply_type                       want;
         tag   = tag_field[atab_pkg::STORE_BITS-1:0];
         hit   = find_tag(tag);
         ok    = 1'b0;
         adm   = 1'b0;
         slot  = 0;
         count = 0;
         case (op)
            atab_pkg::OP_LOOKUP: begin
               if (hit >= 0) begin
                  ok   = 1'b1;
                  slot = hit;
                  adm  = is_admin[hit];
               end
            end
            atab_pkg::OP_ADMIN_LOOKUP: begin
               if (hit >= 0 && is_admin[hit]) begin
                  ok   = 1'b1;
                  slot = hit;
                  adm  = 1'b1;
               end
            end
            atab_pkg::OP_ADD: begin
               if (hit >= 0) begin
                  // An upgrade moves the tag to the lowest free slot once its own is freed.
                  if (grant && !is_admin[hit]) begin
                     occupied[hit] = 1'b0;
                     slot = lowest_free();
                     occupied[slot]   = 1'b1;
                     stored_tag[slot] = tag;
                     is_admin[slot]   = 1'b1;
                     ok  = 1'b1;
                     adm = 1'b1;
                  end
               end else begin
                  slot = lowest_free();
                  if (slot >= 0) begin
                     occupied[slot]   = 1'b1;
                     stored_tag[slot] = tag;
                     is_admin[slot]   = grant;
                     ok  = 1'b1;
                     adm = grant;
                  end else begin
                     slot = 0;
                  end
               end
            end
            atab_pkg::OP_DELETE: begin
               if (hit >= 0) begin
                  ok   = 1'b1;
                  slot = hit;
                  adm  = is_admin[hit];
                  occupied[hit] = 1'b0;
                  is_admin[hit] = 1'b0;
               end
            end
            default: begin
            end
         endcase
         for (int i = 0; i < atab_pkg::TABLE_SLOTS; i++)
            if (occupied[i]) count++;
         want.success     = ok;
         want.slot_index  = ok ? slot[atab_pkg::SLOT_FIELD_BITS-1:0] : '0;
         want.entry_admin = ok && adm;
         want.user_count  = count[atab_pkg::COUNT_FIELD_BITS-1:0];
         want.table_empty = (count == 0);
         awaited.push_back(want);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_response(reply_type got);
         reply_type want;
         if (awaited.size() == 0) begin
            $display("%0t ns: response with no request outstanding, expected none, got %p",
                     $time, got);
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare("success", 32'(want.success), 32'(got.success));
         compare("slot_index", 32'(want.slot_index), 32'(got.slot_index));
         compare("entry_admin", 32'(want.entry_admin), 32'(got.entry_admin));
         compare("user_count", 32'(want.user_count), 32'(got.user_count));
         compare("table_empty", 32'(want.table_empty), 32'(got.table_empty));
      endfunction
   endclass

   localparam int PHASES     = 11;
   localparam int PHASE_LEN  = 150;
   localparam int POOL_SIZE  = 48;
   localparam int DRAIN_WAIT = atab_pkg::TABLE_SLOTS + 8;

   logic clock;
   logic reset;

   atab_req_if req_ch ();
   atab_rsp_if rsp_ch ();

   access_tag_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   tag_table_scoreboard board = new;

   logic [atab_pkg::TAG_FIELD_BITS-1:0] tag_pool[POOL_SIZE];
   int                                  burst_left = 0;
   bit                                  req_idle   = 1'b1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Presents one transaction, waits for it to be taken, then paces the sender.
   task automatic issue(input logic [1:0] op, input logic [atab_pkg::TAG_FIELD_BITS-1:0] tag,
                        input logic grant);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.tag_id      <= tag;
      req_ch.grant_admin <= grant;
      req_idle = 1'b0;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_request(op, tag, grant);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            req_idle = 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [1:0] pick_op(int kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         0:       return (r < 55) ? atab_pkg::OP_ADD : (r < 70) ? atab_pkg::OP_LOOKUP :
                         (r < 85) ? atab_pkg::OP_ADMIN_LOOKUP : atab_pkg::OP_DELETE;
         1:       return (r < 55) ? atab_pkg::OP_DELETE : (r < 70) ? atab_pkg::OP_LOOKUP :
                         (r < 85) ? atab_pkg::OP_ADMIN_LOOKUP : atab_pkg::OP_ADD;
         default: return (r < 25) ? atab_pkg::OP_LOOKUP : (r < 50) ? atab_pkg::OP_ADMIN_LOOKUP :
                         (r < 75) ? atab_pkg::OP_ADD : atab_pkg::OP_DELETE;
      endcase
   endfunction

   function automatic logic [atab_pkg::TAG_FIELD_BITS-1:0] pick_tag(int psize);
      if ($urandom_range(0, 6) == 0) return $urandom;
      return tag_pool[$urandom_range(0, psize - 1)];
   endfunction

   // Receiver: switches between always ready, random stalls and long stall stretches.
   initial begin
      int  mode;
      int  span;
      int  hold;
      bit  rdy;
      hold = 0;
      rdy  = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(50, 400);
         repeat (span) begin
            @(posedge clock);
            if (hold > 0) begin
               hold--;
            end else begin
               case (mode)
                  0: rdy = 1'b1;
                  1: rdy = ($urandom_range(0, 3) != 0);
                  default: begin
                     rdy  = !rdy;
                     hold = rdy ? $urandom_range(0, 4) : $urandom_range(10, 80);
                  end
               endcase
               rsp_ch.ready <= rdy;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         board.check_response('{rsp_ch.success, rsp_ch.slot_index, rsp_ch.entry_admin,
                                rsp_ch.user_count, rsp_ch.table_empty});
   end

   initial begin
      int kind;
      int psize;
      int k;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.operation   = atab_pkg::OP_LOOKUP;
      req_ch.tag_id      = '0;
      req_ch.grant_admin = 1'b0;
      rsp_ch.ready       = 1'b0;

      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
      // A few tags one bit away from another, so the compare must see every bit.
      for (int i = 3; i < 6; i++) tag_pool[i] = tag_pool[2] ^ (32'd1 << $urandom_range(0, 31));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Empty table: nothing matches, not even tag zero; then two tags are added.
      issue(atab_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1);
      issue(atab_pkg::OP_ADMIN_LOOKUP, 32'h0000_0000, 1'b0);
      issue(atab_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b0);
      issue(atab_pkg::OP_ADD, 32'h0000_0000, 1'b0);
      issue(atab_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1);
      issue(atab_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0);
      issue(atab_pkg::OP_ADMIN_LOOKUP, 32'h0000_0000, 1'b1);
      issue(atab_pkg::OP_ADMIN_LOOKUP, 32'hFFFF_FFFF, 1'b0);
      // Adds of tags already present fail unless they upgrade a plain user.
      issue(atab_pkg::OP_ADD, 32'h0000_0000, 1'b0);
      issue(atab_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1);
      issue(atab_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
      issue(atab_pkg::OP_ADD, 32'h5A5A_A5A5, 1'b0);
      issue(atab_pkg::OP_DELETE, 32'h0000_0000, 1'b1);
      // The upgrade frees slot two and lands in the lower free slot zero.
      issue(atab_pkg::OP_ADD, 32'h5A5A_A5A5, 1'b1);
      issue(atab_pkg::OP_LOOKUP, 32'h5A5A_A5A5, 1'b0);
      issue(atab_pkg::OP_ADMIN_LOOKUP, 32'h5A5A_A5A5, 1'b0);
      issue(atab_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b0);
      issue(atab_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0);
      issue(atab_pkg::OP_ADD, 32'h0000_0000, 1'b1);
      issue(atab_pkg::OP_DELETE, 32'h0000_0000, 1'b0);
      issue(atab_pkg::OP_DELETE, 32'h5A5A_A5A5, 1'b0);
      issue(atab_pkg::OP_DELETE, 32'h5A5A_A5A5, 1'b1);

      // Random part: fill phases push the table to full, drain phases empty it again.
      for (int phase = 0; phase < PHASES; phase++) begin
         kind  = (phase < 2) ? phase : $urandom_range(0, 2);
         psize = (kind == 0) ? $urandom_range(36, POOL_SIZE) :
                 (kind == 1) ? POOL_SIZE : $urandom_range(6, POOL_SIZE);
         for (int i = 0; i < 3; i++) begin
            k = $urandom_range(6, POOL_SIZE - 1);
            tag_pool[k] = $urandom;
         end
         for (int i = 0; i < PHASE_LEN; i++)
            issue(pick_op(kind), pick_tag(psize), 1'($urandom_range(0, 1)));
      end

      if (!req_idle) req_ch.valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

### filelist.f
src/atab_pkg.sv
src/atab_if.sv
src/atab_ram.sv
src/access_tag_table.sv
bench/tb_access_tag_table.sv
